FILE: src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define ASSERT_NXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/tdpt_pkg.sv
// Package: types and constants of the trial division prime test.
`timescale 1ns / 1ps

package tdpt_pkg;

    // First trial divisor of every test.
    localparam int FIRST_DIVISOR = 2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCREEN,
        S_START,
        S_DIV,
        S_EVAL,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request value, reset divisor
        logic div_start;   // begin one division of value by divisor
        logic div_step;    // one restoring division step
        logic next_div;    // advance to the next divisor
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic below_two;   // value negative, zero or one
        logic last_step;   // current step is the final division step
        logic quot_lt_div; // quotient below divisor: divisor squared exceeds value
        logic rem_zero;    // remainder is zero
    } t_dp_status;

endpackage

FILE: src/tdpt_ctrl.sv
// Controller: sequences screening, divisions and result hand-off.
`timescale 1ns / 1ps

module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic       o_is_prime,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state, n_state;
    logic   r_result, n_result;
    logic   r_out_valid, n_out_valid;
    logic   r_out_prime, n_out_prime;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_result    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_result    <= n_result;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_out_prime <= n_out_prime;
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_result    = r_result;
        n_out_prime = r_out_prime;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_s_tready  = 1'b0;

        // result taken by the receiver
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCREEN;
                end
            end
            S_SCREEN: begin
                if (i_status.below_two) begin
                    n_result = 1'b0;
                    n_state  = S_FINISH;
                end else begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.last_step) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (i_status.quot_lt_div) begin
                    n_result = 1'b1;
                    n_state  = S_FINISH;
                end else if (i_status.rem_zero) begin
                    n_result = 1'b0;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_START;
                end
            end
            S_FINISH: begin
                // wait for the output register to free up
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_is_prime = r_out_prime;

endmodule

FILE: src/tdpt_dp.sv
// Datapath: value, divisor and a bit-serial restoring divider.
`timescale 1ns / 1ps

module tdpt_dp
    import tdpt_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_value,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_status
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_value;
    logic [WIDTH-1:0] r_divisor;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quot;
    logic [CW-1:0]    r_count;

    logic [WIDTH-1:0] shift_rem;
    logic [WIDTH:0]   diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shift_rem = {r_rem[WIDTH-2:0], r_quot[WIDTH-1]};
        diff      = {1'b0, shift_rem} - {1'b0, r_divisor};
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value   <= i_value;
            r_divisor <= WIDTH'(FIRST_DIVISOR);
        end
        if (i_cmd.next_div) begin
            r_divisor <= r_divisor + WIDTH'(1);
        end
        if (i_cmd.div_start) begin
            r_quot  <= r_value;
            r_rem   <= '0;
            r_count <= '0;
        end else if (i_cmd.div_step) begin
            r_count <= r_count + CW'(1);
            if (!diff[WIDTH]) begin
                r_rem  <= diff[WIDTH-1:0];
                r_quot <= {r_quot[WIDTH-2:0], 1'b1};
            end else begin
                r_rem  <= shift_rem;
                r_quot <= {r_quot[WIDTH-2:0], 1'b0};
            end
        end
    end

    // Status back to the controller
    always_comb begin
        o_status.below_two   = r_value[WIDTH-1] || (r_value < WIDTH'(FIRST_DIVISOR));
        o_status.last_step   = (r_count == CW'(WIDTH - 1));
        o_status.quot_lt_div = (r_quot < r_divisor);
        o_status.rem_zero    = (r_rem == '0);
    end

endmodule

FILE: src/trial_division_prime_test_core.sv
// Top level: trial division primality test with stream channels.
`timescale 1ns / 1ps
// Usage:
//   Input channel i_s_*: one request per signed value (two's complement, WIDTH bits).
//   Output channel o_m_*: one result per request, bit 0 of tdata is 1 for a prime.
//   Requests are handled one at a time; o_s_tready is high only while idle.
// Sequence:
//   Negative values, zero and one: screened out, no division is run.
//   Otherwise each trial divisor runs a start state, WIDTH steps of the
//   bit-serial divider and an evaluate state. For WIDTH=32 the worst case,
//   a prime near 2^31, runs about 46340 divisors. All divisions share the
//   one restoring divider.
// Stalls:
//   A finished result waits in the output register; the next request is
//   accepted and worked on meanwhile, and its result waits for the slot.
// Reset:
//   i_rst_n (synchronous, active low) returns to idle and drops o_m_tvalid.

module trial_division_prime_test_core
    import tdpt_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [((WIDTH + 7) / 8)*8-1:0]  i_s_tdata,   // [WIDTH-1:0] value
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [7:0]                      o_m_tdata    // [0] is_prime
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       is_prime;

    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_is_prime (is_prime),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    tdpt_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_value  (i_s_tdata[WIDTH-1:0]),
        .i_cmd    (cmd),
        .o_status (status)
    );

    // Pad the result to a whole byte
    assign o_m_tdata = {7'b0, is_prime};

endmodule

FILE: src/tdpt_checker.sv
// Checker on the top-level ports, bound to the core.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdpt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    // A stalled result stays offered
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // A stalled result keeps its value
    `ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata))

    // One request at a time: busy right after accepting
    `ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // No result is offered right after reset
    `ASSERT_NXT_ALL(a_reset_clears, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
